// ===== design/zuc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zuc_pkg
// shared types, constants and s-box tables for the zuc eea3 cipher
// ----------------------------------------------------------------------------
package zuc_pkg;

  localparam int CellW    = 31;
  localparam int NumCells = 16;
  localparam int InitRnds = 32;
  localparam int RndCntW  = 6;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 64;

  localparam logic [CfgIdxW-1:0] RegKeyHigh = 3'd0;
  localparam logic [CfgIdxW-1:0] RegKeyLow  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegCount   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegBearer  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegDir     = 3'd4;

  localparam logic ModeStart = 1'b0;
  localparam logic ModeData  = 1'b1;

  typedef logic [CellW-1:0] cell_t;

  // datapath commands
  typedef struct packed {
    logic load;      // load cells from key, d and iv
    logic init_rnd;  // init round, feed w >> 1
    logic work_rnd;  // work round, lfsr feedback without w
    logic capture;   // register the output word
  } dp_cmd_t;

  typedef struct packed {
    logic [31:0] data_word;
    logic        last;
    logic [5:0]  valid_bits;
  } dp_item_t;

  localparam logic [15:0] DConst [NumCells] = '{
    16'h44d7, 16'h26bc, 16'h626b, 16'h135e, 16'h5789, 16'h35e2, 16'h7135, 16'h09af,
    16'h4d78, 16'h2f13, 16'h6bc4, 16'h1af1, 16'h5e26, 16'h3c4d, 16'h789a, 16'h47ac
  };

  localparam logic [7:0] Sbox0 [256] = '{
    8'h3e,8'h72,8'h5b,8'h47,8'hca,8'he0,8'h00,8'h33,8'h04,8'hd1,8'h54,8'h98,8'h09,8'hb9,8'h6d,8'hcb,
    8'h7b,8'h1b,8'hf9,8'h32,8'haf,8'h9d,8'h6a,8'ha5,8'hb8,8'h2d,8'hfc,8'h1d,8'h08,8'h53,8'h03,8'h90,
    8'h4d,8'h4e,8'h84,8'h99,8'he4,8'hce,8'hd9,8'h91,8'hdd,8'hb6,8'h85,8'h48,8'h8b,8'h29,8'h6e,8'hac,
    8'hcd,8'hc1,8'hf8,8'h1e,8'h73,8'h43,8'h69,8'hc6,8'hb5,8'hbd,8'hfd,8'h39,8'h63,8'h20,8'hd4,8'h38,
    8'h76,8'h7d,8'hb2,8'ha7,8'hcf,8'hed,8'h57,8'hc5,8'hf3,8'h2c,8'hbb,8'h14,8'h21,8'h06,8'h55,8'h9b,
    8'he3,8'hef,8'h5e,8'h31,8'h4f,8'h7f,8'h5a,8'ha4,8'h0d,8'h82,8'h51,8'h49,8'h5f,8'hba,8'h58,8'h1c,
    8'h4a,8'h16,8'hd5,8'h17,8'ha8,8'h92,8'h24,8'h1f,8'h8c,8'hff,8'hd8,8'hae,8'h2e,8'h01,8'hd3,8'had,
    8'h3b,8'h4b,8'hda,8'h46,8'heb,8'hc9,8'hde,8'h9a,8'h8f,8'h87,8'hd7,8'h3a,8'h80,8'h6f,8'h2f,8'hc8,
    8'hb1,8'hb4,8'h37,8'hf7,8'h0a,8'h22,8'h13,8'h28,8'h7c,8'hcc,8'h3c,8'h89,8'hc7,8'hc3,8'h96,8'h56,
    8'h07,8'hbf,8'h7e,8'hf0,8'h0b,8'h2b,8'h97,8'h52,8'h35,8'h41,8'h79,8'h61,8'ha6,8'h4c,8'h10,8'hfe,
    8'hbc,8'h26,8'h95,8'h88,8'h8a,8'hb0,8'ha3,8'hfb,8'hc0,8'h18,8'h94,8'hf2,8'he1,8'he5,8'he9,8'h5d,
    8'hd0,8'hdc,8'h11,8'h66,8'h64,8'h5c,8'hec,8'h59,8'h42,8'h75,8'h12,8'hf5,8'h74,8'h9c,8'haa,8'h23,
    8'h0e,8'h86,8'hab,8'hbe,8'h2a,8'h02,8'he7,8'h67,8'he6,8'h44,8'ha2,8'h6c,8'hc2,8'h93,8'h9f,8'hf1,
    8'hf6,8'hfa,8'h36,8'hd2,8'h50,8'h68,8'h9e,8'h62,8'h71,8'h15,8'h3d,8'hd6,8'h40,8'hc4,8'he2,8'h0f,
    8'h8e,8'h83,8'h77,8'h6b,8'h25,8'h05,8'h3f,8'h0c,8'h30,8'hea,8'h70,8'hb7,8'ha1,8'he8,8'ha9,8'h65,
    8'h8d,8'h27,8'h1a,8'hdb,8'h81,8'hb3,8'ha0,8'hf4,8'h45,8'h7a,8'h19,8'hdf,8'hee,8'h78,8'h34,8'h60
  };

  localparam logic [7:0] Sbox1 [256] = '{
    8'h55,8'hc2,8'h63,8'h71,8'h3b,8'hc8,8'h47,8'h86,8'h9f,8'h3c,8'hda,8'h5b,8'h29,8'haa,8'hfd,8'h77,
    8'h8c,8'hc5,8'h94,8'h0c,8'ha6,8'h1a,8'h13,8'h00,8'he3,8'ha8,8'h16,8'h72,8'h40,8'hf9,8'hf8,8'h42,
    8'h44,8'h26,8'h68,8'h96,8'h81,8'hd9,8'h45,8'h3e,8'h10,8'h76,8'hc6,8'ha7,8'h8b,8'h39,8'h43,8'he1,
    8'h3a,8'hb5,8'h56,8'h2a,8'hc0,8'h6d,8'hb3,8'h05,8'h22,8'h66,8'hbf,8'hdc,8'h0b,8'hfa,8'h62,8'h48,
    8'hdd,8'h20,8'h11,8'h06,8'h36,8'hc9,8'hc1,8'hcf,8'hf6,8'h27,8'h52,8'hbb,8'h69,8'hf5,8'hd4,8'h87,
    8'h7f,8'h84,8'h4c,8'hd2,8'h9c,8'h57,8'ha4,8'hbc,8'h4f,8'h9a,8'hdf,8'hfe,8'hd6,8'h8d,8'h7a,8'heb,
    8'h2b,8'h53,8'hd8,8'h5c,8'ha1,8'h14,8'h17,8'hfb,8'h23,8'hd5,8'h7d,8'h30,8'h67,8'h73,8'h08,8'h09,
    8'hee,8'hb7,8'h70,8'h3f,8'h61,8'hb2,8'h19,8'h8e,8'h4e,8'he5,8'h4b,8'h93,8'h8f,8'h5d,8'hdb,8'ha9,
    8'had,8'hf1,8'hae,8'h2e,8'hcb,8'h0d,8'hfc,8'hf4,8'h2d,8'h46,8'h6e,8'h1d,8'h97,8'he8,8'hd1,8'he9,
    8'h4d,8'h37,8'ha5,8'h75,8'h5e,8'h83,8'h9e,8'hab,8'h82,8'h9d,8'hb9,8'h1c,8'he0,8'hcd,8'h49,8'h89,
    8'h01,8'hb6,8'hbd,8'h58,8'h24,8'ha2,8'h5f,8'h38,8'h78,8'h99,8'h15,8'h90,8'h50,8'hb8,8'h95,8'he4,
    8'hd0,8'h91,8'hc7,8'hce,8'hed,8'h0f,8'hb4,8'h6f,8'ha0,8'hcc,8'hf0,8'h02,8'h4a,8'h79,8'hc3,8'hde,
    8'ha3,8'hef,8'hea,8'h51,8'he6,8'h6b,8'h18,8'hec,8'h1b,8'h2c,8'h80,8'hf7,8'h74,8'he7,8'hff,8'h21,
    8'h5a,8'h6a,8'h54,8'h1e,8'h41,8'h31,8'h92,8'h35,8'hc4,8'h33,8'h07,8'h0a,8'hba,8'h7e,8'h0e,8'h34,
    8'h88,8'hb1,8'h98,8'h7c,8'hf3,8'h3d,8'h60,8'h6c,8'h7b,8'hca,8'hd3,8'h1f,8'h32,8'h65,8'h04,8'h28,
    8'h64,8'hbe,8'h85,8'h9b,8'h2f,8'h59,8'h8a,8'hd7,8'hb0,8'h25,8'hac,8'haf,8'h12,8'h03,8'he2,8'hf2
  };

  function automatic logic [31:0] sbox_word(input logic [31:0] x);
    sbox_word = {Sbox0[x[31:24]], Sbox1[x[23:16]], Sbox0[x[15:8]], Sbox1[x[7:0]]};
  endfunction

endpackage

// ===== design/zuc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zuc_in_if / zuc_out_if
// valid/ready channels for input and output words
// ----------------------------------------------------------------------------
interface zuc_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [31:0] data_word;
  logic        last;
  logic [5:0]  valid_bits;
  modport source (output valid, mode, data_word, last, valid_bits, input ready);
  modport sink (input valid, mode, data_word, last, valid_bits, output ready);
endinterface

interface zuc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_word;
  logic        out_last;
  modport source (output valid, out_word, out_last, input ready);
  modport sink (input valid, out_word, out_last, output ready);
endinterface

// ===== design/zuc_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zuc_datapath
// lfsr cells, r1/r2, one round per cycle on command, the output word register
// ----------------------------------------------------------------------------
module zuc_datapath (
  input  logic              clk,
  input  logic [63:0]       key_high,
  input  logic [63:0]       key_low,
  input  logic [31:0]       frame_count,
  input  logic [4:0]        bearer_id,
  input  logic              link_direction,
  input  logic              rst,
  input  zuc_pkg::dp_cmd_t  cmd,
  input  zuc_pkg::dp_item_t item,
  output logic [31:0]       out_word,
  output logic              out_last
);
  import zuc_pkg::*;

  cell_t       cells [NumCells];
  logic [31:0] r1, r2;
  logic [31:0] x0, x1, x2, x3, w, w1, w2, ta, tb, z, r;
  logic [7:0]  iv [NumCells];
  cell_t       fb;
  logic [31:0] sum, mask;
  logic [5:0]  vb;

  function automatic cell_t add31(input cell_t a, input cell_t b);
    logic [31:0] c;
    c = {1'b0, a} + {1'b0, b};
    add31 = c[31] ? (c[30:0] + 31'd1) : c[30:0];
  endfunction

  function automatic cell_t rot31(input cell_t x, input int k);
    rot31 = cell_t'((x << k) | (x >> (31 - k)));
  endfunction

  always_comb begin
    x0 = {cells[15][30:15], cells[14][15:0]};
    x1 = {cells[11][15:0], cells[9][30:15]};
    x2 = {cells[7][15:0], cells[5][30:15]};
    x3 = {cells[2][15:0], cells[0][30:15]};
    w  = (x0 ^ r1) + r2;
    w1 = r1 + x1;
    w2 = r2 ^ x2;
    ta = {w1[15:0], w2[31:16]};
    tb = {w2[15:0], w1[31:16]};
    fb = add31(add31(add31(cells[0], rot31(cells[15], 15)),
                     add31(rot31(cells[13], 17), rot31(cells[10], 21))),
               add31(rot31(cells[4], 20), rot31(cells[0], 8)));
    if (cmd.init_rnd) fb = add31(fb, w[31:1]);
    z = w ^ x3;
    r = item.data_word ^ z;
    vb = item.valid_bits;
    mask = '1;
    if (item.last && vb >= 6'd1 && vb <= 6'd31) mask = ~(32'hffffffff >> vb);
    sum = r & mask;
    iv[4] = {bearer_id, link_direction, 2'b00};
    {iv[0], iv[1], iv[2], iv[3]} = frame_count;
    iv[5] = '0; iv[6] = '0; iv[7] = '0;
    for (int i = 0; i < 8; i++) iv[i + 8] = iv[i];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumCells; i++) cells[i] <= '0;
      r1 <= '0;
      r2 <= '0;
    end else if (cmd.load) begin
      for (int i = 0; i < 8; i++) begin
        cells[i]     <= {key_high[63-8*i -: 8], DConst[i][14:0], iv[i]};
        cells[i + 8] <= {key_low[63-8*i -: 8], DConst[i + 8][14:0], iv[i + 8]};
      end
      r1 <= '0;
      r2 <= '0;
    end else if (cmd.init_rnd || cmd.work_rnd) begin
      for (int i = 0; i < NumCells - 1; i++) cells[i] <= cells[i + 1];
      cells[NumCells-1] <= (fb == '0) ? '1 : fb;
      r1 <= sbox_word(ta ^ {ta[29:0], ta[31:30]} ^ {ta[21:0], ta[31:22]}
                      ^ {ta[13:0], ta[31:14]} ^ {ta[7:0], ta[31:8]});
      r2 <= sbox_word(tb ^ {tb[23:0], tb[31:24]} ^ {tb[17:0], tb[31:18]}
                      ^ {tb[9:0], tb[31:10]} ^ {tb[1:0], tb[31:2]});
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      out_word <= sum;
      out_last <= item.last;
    end
  end
endmodule

// ===== design/zuc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zuc_ctrl
// sequences init rounds and hands out datapath commands
// ----------------------------------------------------------------------------
module zuc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_mode,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output zuc_pkg::dp_cmd_t cmd
);
  import zuc_pkg::*;

  typedef enum logic [1:0] {IDLE, INIT, WORK} state_t;
  state_t state;
  logic [RndCntW-1:0] cnt;
  logic take;

  // a word can be taken while the output holds one that leaves this cycle
  assign in_ready = (state == IDLE) && (!out_valid || out_ready);
  assign take = in_valid && in_ready;

  always_comb begin
    cmd = '0;
    cmd.load     = take && in_mode == ModeStart;
    cmd.work_rnd = (take && in_mode == ModeData) || state == WORK;
    cmd.capture  = take && in_mode == ModeData;
    cmd.init_rnd = state == INIT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.capture) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        IDLE: begin
          if (cmd.load) begin
            state <= INIT;
            cnt <= '0;
          end
        end
        INIT: begin
          cnt <= cnt + 1'b1;
          if (cnt == RndCntW'(InitRnds - 1)) state <= WORK;
        end
        WORK: state <= IDLE;
        default: state <= IDLE;
      endcase
    end
  end

  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    state != IDLE |-> !in_ready) else $error("word taken while busy");
  a_init_len: assert property (@(posedge clk) disable iff (rst)
    state == INIT && cnt == RndCntW'(InitRnds - 1) |=> state == WORK)
    else $error("init length wrong");
  a_start_no_out: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> $stable(out_valid) || !out_valid) else $error("start produced word");
endmodule

// ===== design/zuc_eea3_cipher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zuc_eea3_cipher
// zuc-128 keystream engine used as the eea3 confidentiality cipher
// ----------------------------------------------------------------------------
// usage:
//   write key_high, key_low, frame_count, bearer_id and link_direction
//   through the cfg port while idle, then send a start word (mode 0).
//   a start word yields no output and keeps in.ready low while its rounds run
//   (32 init rounds and one discarded work round on the shared round unit).
//   each data word (mode 1) is combined with one keystream word in one
//   round; the result is registered and appears in the cycle after accept.
//   data words are taken one per cycle unless the output stalls, set by the
//   single round unit. the last word keeps only its leading valid_bits bits
//   (1 to 31). if the receiver stalls, the output word holds and in.ready
//   stays low until taken. reset clears every register but the output word.
// ----------------------------------------------------------------------------
module zuc_eea3_cipher (
  input  logic                         clk,
  input  logic                         rst,
  zuc_in_if.sink                       in,
  zuc_out_if.source                    out,
  input  logic                         cfg_we,
  input  logic [zuc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [zuc_pkg::CfgDataW-1:0] cfg_data
);
  import zuc_pkg::*;

  logic [63:0] key_high, key_low;
  logic [31:0] frame_count;
  logic [4:0]  bearer_id;
  logic        link_direction;
  dp_cmd_t     cmd;
  dp_item_t    item;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low <= '0;
      frame_count <= '0;
      bearer_id <= '0;
      link_direction <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegKeyHigh: key_high <= cfg_data;
        RegKeyLow:  key_low <= cfg_data;
        RegCount:   frame_count <= cfg_data[31:0];
        RegBearer:  bearer_id <= cfg_data[4:0];
        RegDir:     link_direction <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign item = '{data_word: in.data_word, last: in.last, valid_bits: in.valid_bits};

  zuc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in.valid), .in_mode(in.mode), .in_ready(in.ready),
    .out_valid(out.valid), .out_ready(out.ready), .cmd(cmd)
  );

  zuc_datapath u_dp (
    .clk(clk), .key_high(key_high), .key_low(key_low), .frame_count(frame_count),
    .bearer_id(bearer_id), .link_direction(link_direction), .rst(rst), .cmd(cmd),
    .item(item), .out_word(out.out_word), .out_last(out.out_last)
  );
endmodule
